FILE: rtl/vpts_pkg.sv
package vpts_pkg;

  localparam int COEF_DEPTH = 25;
  localparam int PRJ_BASE   = 12;
  localparam int VPT_BASE   = 19;
  localparam int NSTG       = 16;
  localparam int DIV_STEPS  = 7;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_POINT = 1'b1;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_HALF = 32'h3F00_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [31:0] FP_SIGN = 32'h8000_0000;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  coef_index;
    logic [31:0] coef_value;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
  } vpts_req_t;

  typedef struct packed {
    logic [31:0] screen_x;
    logic [31:0] screen_y;
    logic [31:0] screen_z;
  } vpts_res_t;

  // Everything one point carries down the pipeline
  typedef struct packed {
    logic [31:0]        x;
    logic [31:0]        y;
    logic [31:0]        z;
    logic [11:0][31:0]  mat;
    logic [6:0][31:0]   prj;
    logic [5:0][31:0]   vpt;
    logic [2:0][31:0]   acc;
    logic [2:0][31:0]   tmp;
    logic [4:0][31:0]   prd;
    logic               persp;
    logic [2:0][31:0]   clip;
    logic               rsp;
    logic [31:0]        rspv;
    logic               rsign;
    logic [23:0]        md;
    logic signed [10:0] ed;
    logic [24:0]        rr;
    logic [27:0]        q;
    logic [31:0]        wc;
    logic [2:0][31:0]   pw;
    logic [31:0]        h2;
    logic [31:0]        h3;
    logic [31:0]        dv;
    logic [31:0]        bx;
    logic [31:0]        by;
    logic [2:0][31:0]   scr;
  } vpts_stage_t;

  // Round to nearest even and pack; m has its leading one at bit 26,
  // value is m * 2^(e - 153), bit 0 is sticky
  function automatic logic [31:0] fp_round(input logic s, input logic signed [10:0] e,
                                           input logic [26:0] m);
    logic [26:0]        mm;
    logic [7:0]         ef;
    logic [30:0]        body;
    logic               up;
    logic signed [10:0] shf;
    logic [4:0]         sh;
    logic [31:0]        r;
    mm  = m;
    ef  = 8'd0;
    shf = 11'sd0;
    sh  = 5'd0;
    if (e >= 11'sd255) begin
      r = {s, 8'hFF, 23'd0};
    end else begin
      if (e <= 11'sd0) begin
        if (e < -11'sd26) begin
          mm = {26'd0, |m};
        end else begin
          shf = 11'sd1 - e;
          sh  = shf[4:0];
          mm  = (m >> sh) | {26'd0, |(m & ~({27{1'b1}} << sh))};
        end
      end else begin
        ef = e[7:0];
      end
      up   = mm[2] & (mm[3] | mm[1] | mm[0]);
      body = {ef, mm[25:3]} + {30'd0, up};
      r    = {s, body};
    end
    return r;
  endfunction

  function automatic logic [5:0] lead48(input logic [47:0] v);
    logic [5:0] l;
    l = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) l = 6'(i);
    end
    return l;
  endfunction

  function automatic logic [4:0] lead28(input logic [27:0] v);
    logic [4:0] l;
    l = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) l = 5'(i);
    end
    return l;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic               s, nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
    logic [23:0]        ma, mb;
    logic [7:0]         xa, xb;
    logic [47:0]        p, n;
    logic [5:0]         l;
    logic [26:0]        m;
    logic signed [10:0] e;
    logic [31:0]        r;
    s     = a[31] ^ b[31];
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    zer_a = (a[30:0] == 31'd0);
    zer_b = (b[30:0] == 31'd0);
    ma    = {a[30:23] != 8'd0, a[22:0]};
    mb    = {b[30:23] != 8'd0, b[22:0]};
    xa    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    xb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p     = ma * mb;
    l     = lead48(p);
    n     = p << (6'd47 - l);
    m     = {n[47:22], n[21] | (|n[20:0])};
    e     = $signed({3'd0, xa}) + $signed({3'd0, xb}) + $signed({5'd0, l}) - 11'sd173;
    if (nan_a || nan_b || (inf_a && zer_b) || (zer_a && inf_b)) begin
      r = FP_QNAN;
    end else if (inf_a || inf_b) begin
      r = {s, 8'hFF, 23'd0};
    end else if (zer_a || zer_b) begin
      r = {s, 31'd0};
    end else begin
      r = fp_round(s, e, m);
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic               nan_a, nan_b, inf_a, inf_b;
    logic [31:0]        big, sml;
    logic [23:0]        mbig, msml;
    logic [7:0]         xbig, xsml, d;
    logic [26:0]        bs0;
    logic [27:0]        aa, bb, sum;
    logic [4:0]         l;
    logic [26:0]        m;
    logic signed [10:0] e;
    logic [31:0]        r;
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    mbig = {big[30:23] != 8'd0, big[22:0]};
    msml = {sml[30:23] != 8'd0, sml[22:0]};
    xbig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    xsml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = xbig - xsml;
    bs0  = {msml, 3'd0};
    aa   = {1'b0, mbig, 3'd0};
    if (d >= 8'd27) begin
      bb = {27'd0, |msml};
    end else begin
      bb = {1'b0, (bs0 >> d[4:0]) | {26'd0, |(bs0 & ~({27{1'b1}} << d[4:0]))}};
    end
    sum = (big[31] == sml[31]) ? aa + bb : aa - bb;
    l   = lead28(sum);
    if (l == 5'd27) begin
      m = {sum[27:2], sum[1] | sum[0]};
    end else begin
      m = sum[26:0] << (5'd26 - l);
    end
    e = $signed({3'd0, xbig}) + $signed({6'd0, l}) - 11'sd26;
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) begin
      r = FP_QNAN;
    end else if (inf_a) begin
      r = a;
    end else if (inf_b) begin
      r = b;
    end else if (sum == 28'd0) begin
      r = (big[31] == sml[31]) ? {big[31], 31'd0} : 32'd0;
    end else begin
      r = fp_round(big[31], e, m);
    end
    return r;
  endfunction

  function automatic logic [31:0] fp_canon(input logic [31:0] a);
    logic [31:0] r;
    r = a;
    if ((a[30:23] == 8'hFF) && (a[22:0] != 23'd0)) r = FP_QNAN;
    return r;
  endfunction

  // Work of pipeline stage k on the item leaving stage k-1
  function automatic vpts_stage_t stage_fn(input logic [4:0] k, input vpts_stage_t s);
    vpts_stage_t r;
    logic [31:0] dd;
    logic [23:0] mn;
    logic [7:0]  xn;
    logic [4:0]  ln;
    logic        ge;
    r  = s;
    dd = s.acc[2] ^ FP_SIGN;
    mn = {dd[30:23] != 8'd0, dd[22:0]};
    xn = (dd[30:23] == 8'd0) ? 8'd1 : dd[30:23];
    ln = lead28({4'd0, mn});
    ge = 1'b0;
    case (k)
      5'd1: for (int i = 0; i < 3; i++) r.tmp[i] = fp_mul(s.mat[i*4], s.x);
      5'd2: for (int i = 0; i < 3; i++) r.acc[i] = fp_add(s.mat[i*4+3], s.tmp[i]);
      5'd3: for (int i = 0; i < 3; i++) r.tmp[i] = fp_mul(s.mat[i*4+1], s.y);
      5'd4: for (int i = 0; i < 3; i++) r.acc[i] = fp_add(s.acc[i], s.tmp[i]);
      5'd5: for (int i = 0; i < 3; i++) r.tmp[i] = fp_mul(s.mat[i*4+2], s.z);
      5'd6: for (int i = 0; i < 3; i++) r.acc[i] = fp_add(s.acc[i], s.tmp[i]);
      5'd7: begin
        // projection products and reciprocal setup for w = 1/(-ez)
        r.prd[0] = fp_mul(s.acc[0], s.prj[1]);
        r.prd[1] = fp_mul(s.acc[2], s.prj[2]);
        r.prd[2] = fp_mul(s.acc[1], s.prj[3]);
        r.prd[3] = fp_mul(s.acc[2], s.prj[4]);
        r.prd[4] = fp_mul(s.acc[2], s.prj[5]);
        r.persp  = (s.prj[0][30:0] == 31'd0);
        r.rsign  = dd[31];
        r.rsp    = (dd[30:23] == 8'hFF) || (dd[30:0] == 31'd0);
        if ((dd[30:23] == 8'hFF) && (dd[22:0] != 23'd0)) begin
          r.rspv = FP_QNAN;
        end else if (dd[30:23] == 8'hFF) begin
          r.rspv = {dd[31], 31'd0};
        end else begin
          r.rspv = {dd[31], 8'hFF, 23'd0};
        end
        r.md = mn << (5'd23 - ln);
        r.ed = $signed({3'd0, xn}) + $signed({6'd0, ln}) - 11'sd23;
        r.rr = 25'h080_0000;
        r.q  = 28'd0;
      end
      5'd8, 5'd9, 5'd10, 5'd11: begin
        if (k == 5'd8) begin
          r.clip[0] = s.persp ? fp_add(s.prd[0], s.prd[1]) : fp_add(s.prj[2], s.prd[0]);
          r.clip[1] = s.persp ? fp_add(s.prd[2], s.prd[3]) : fp_add(s.prj[4], s.prd[2]);
          r.clip[2] = fp_add(s.prj[6], s.prd[4]);
        end
        // restoring divide of 2^50 by the divisor mantissa
        for (int j = 0; j < DIV_STEPS; j++) begin
          ge = (r.rr >= {1'b0, r.md});
          if (ge) r.rr = r.rr - {1'b0, r.md};
          r.q  = {r.q[26:0], ge};
          r.rr = r.rr << 1;
        end
      end
      5'd12: begin
        if (!s.persp) begin
          r.wc = FP_ONE;
        end else if (s.rsp) begin
          r.wc = s.rspv;
        end else if (s.q[27]) begin
          r.wc = fp_round(s.rsign, 11'sd254 - s.ed, {s.q[27:2], s.q[1] | s.q[0] | (|s.rr)});
        end else begin
          r.wc = fp_round(s.rsign, 11'sd253 - s.ed, {s.q[26:1], s.q[0] | (|s.rr)});
        end
      end
      5'd13: begin
        for (int i = 0; i < 3; i++) r.pw[i] = fp_mul(s.wc, s.clip[i]);
        r.h2 = fp_mul(s.vpt[2], FP_HALF);
        r.h3 = fp_mul(s.vpt[3], FP_HALF);
        r.dv = fp_add(s.vpt[5], s.vpt[4] ^ FP_SIGN);
      end
      5'd14: begin
        r.pw[0] = fp_mul(s.pw[0], s.vpt[2]);
        r.pw[1] = fp_mul(s.pw[1], s.vpt[3]);
        r.pw[2] = fp_mul(s.pw[2], s.dv);
        r.bx    = fp_add(s.h2, s.vpt[0]);
        r.by    = fp_add(s.h3, s.vpt[1]);
      end
      5'd15: begin
        r.pw[0] = fp_mul(s.pw[0], FP_HALF);
        r.pw[1] = fp_mul(s.pw[1], FP_HALF);
        r.scr[2] = fp_add(s.vpt[5], s.pw[2]);
      end
      5'd16: begin
        r.scr[0] = fp_canon(fp_add(s.bx, s.pw[0]));
        r.scr[1] = fp_canon(fp_add(s.by, s.pw[1] ^ FP_SIGN));
        r.scr[2] = fp_canon(s.scr[2]);
      end
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/vertex_project_to_screen_unit.sv
// Projects an object-space point to screen coordinates in IEEE single precision, round to
// nearest even, subnormals kept. A load request (req_type 0) writes one of the 25 coefficient
// words (matrix 0-11, projection 12-18, viewport 19-24) and returns nothing; a point request
// returns one result through the entry register and the stages. One item enters per cycle
// while the output is not stalled. The pipeline is 16 stages behind the entry register;
// its length is set by the chain of dependent multiplies and adds and by the reciprocal
// 1/(-ez), a restoring divider spread over four stages of seven quotient bits. Each point
// takes a copy of the coefficients at transfer, so loads may follow points without waiting.
module vertex_project_to_screen_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  vpts_pkg::vpts_req_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output vpts_pkg::vpts_res_t res
);

  logic [31:0]           coef [vpts_pkg::COEF_DEPTH];
  vpts_pkg::vpts_stage_t stg [vpts_pkg::NSTG+1];
  vpts_pkg::vpts_stage_t entry;
  logic [vpts_pkg::NSTG:0]   vld;
  logic [vpts_pkg::NSTG+1:0] en;
  logic                      take;

  assign take = req_valid && req_ready;

  // Write the coefficient store on a load transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vpts_pkg::COEF_DEPTH; i++) coef[i] <= 32'd0;
    end else if (take && (req.req_type == vpts_pkg::REQ_LOAD) &&
                 (req.coef_index < 5'(vpts_pkg::COEF_DEPTH))) begin
      coef[req.coef_index] <= req.coef_value;
    end
  end

  // Build the entry item from the point and a copy of the coefficients
  always_comb begin
    entry   = '0;
    entry.x = req.point_x;
    entry.y = req.point_y;
    entry.z = req.point_z;
    for (int i = 0; i < 12; i++) entry.mat[i] = coef[i];
    for (int i = 0; i < 7; i++) entry.prj[i] = coef[vpts_pkg::PRJ_BASE + i];
    for (int i = 0; i < 6; i++) entry.vpt[i] = coef[vpts_pkg::VPT_BASE + i];
  end

  // A stage advances when it is empty or the next one advances
  always_comb begin
    en[vpts_pkg::NSTG+1] = res_ready;
    for (int k = vpts_pkg::NSTG; k >= 0; k--) en[k] = !vld[k] || en[k+1];
  end

  assign req_ready = en[0];

  // Hold valid bits per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= take && (req.req_type == vpts_pkg::REQ_POINT);
      for (int k = 1; k <= vpts_pkg::NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) stg[0] <= entry;
  end

  for (genvar k = 1; k <= vpts_pkg::NSTG; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[k]) stg[k] <= vpts_pkg::stage_fn(5'(k), stg[k-1]);
    end
  end

  assign res_valid     = vld[vpts_pkg::NSTG];
  assign res.screen_x  = stg[vpts_pkg::NSTG].scr[0];
  assign res.screen_y  = stg[vpts_pkg::NSTG].scr[1];
  assign res.screen_z  = stg[vpts_pkg::NSTG].scr[2];

  // An empty output slot always lets the input side move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[vpts_pkg::NSTG] |-> req_ready)
    else $error("input stalled with empty output stage");

  // A load never enters the pipeline
  a_load_no_item: assert property (@(posedge clk) disable iff (rst)
    (take && (req.req_type == vpts_pkg::REQ_LOAD)) |=> !vld[0])
    else $error("load produced a pipeline item");

  // A point transfer always lands in the entry stage
  a_point_enters: assert property (@(posedge clk) disable iff (rst)
    (take && (req.req_type == vpts_pkg::REQ_POINT)) |=> vld[0])
    else $error("point transfer lost");

endmodule
